>>> hw/rtl/dcc_pkg.sv
package dcc_pkg;

    typedef enum logic [1:0] {
        REQ_CTRL = 2'd0,
        REQ_TRIG = 2'd1,
        REQ_STEP = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        TRIG_HBLANK = 2'd0,
        TRIG_VBLANK = 2'd1,
        TRIG_FIFO_A = 2'd2,
        TRIG_FIFO_B = 2'd3
    } trig_kind_t;

    typedef enum logic [1:0] {
        TIME_NOW     = 2'd0,
        TIME_VBLANK  = 2'd1,
        TIME_HBLANK  = 2'd2,
        TIME_SPECIAL = 2'd3
    } timing_t;

    typedef enum logic [1:0] {
        ADDR_INC    = 2'd0,
        ADDR_DEC    = 2'd1,
        ADDR_FIXED  = 2'd2,
        ADDR_RELOAD = 2'd3
    } addr_mode_t;

    typedef enum logic [1:0] {
        CFG_SRC   = 2'd0,
        CFG_DST   = 2'd1,
        CFG_COUNT = 2'd2,
        CFG_CHAN  = 2'd3
    } cfg_index_t;

    localparam int unsigned ADDR_W  = 28;
    localparam int unsigned PTR_W   = 32;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned CTRL_W  = 16;
    localparam int unsigned PADDR_W = 4;

    localparam logic [1:0] LAST_CHANNEL = 2'd3;

    localparam logic [ADDR_W-1:0]  FIFO_A_ADDR = 28'h40000A0;
    localparam logic [ADDR_W-1:0]  FIFO_B_ADDR = 28'h40000A4;
    localparam logic [ADDR_W-1:0]  MASK_27     = 28'h7FFFFFF;
    localparam logic [15:0]        MASK_14     = 16'h3FFF;
    localparam logic [COUNT_W-1:0] MAX_COUNT_SHORT = 17'h04000;
    localparam logic [COUNT_W-1:0] MAX_COUNT_LONG  = 17'h10000;
    localparam logic [COUNT_W-1:0] FIFO_BURST      = 17'd4;

    localparam int unsigned BIT_DMODE  = 5;
    localparam int unsigned BIT_SMODE  = 7;
    localparam int unsigned BIT_REPEAT = 9;
    localparam int unsigned BIT_WORD   = 10;
    localparam int unsigned BIT_TIMING = 12;
    localparam int unsigned BIT_IRQ    = 14;
    localparam int unsigned BIT_ENABLE = 15;

    typedef struct packed {
        logic [CTRL_W-1:0] control_value;
        logic              start_request;
        logic              xfer_valid;
        logic              xfer_word32;
        logic [PTR_W-1:0]  src_addr;
        logic [PTR_W-1:0]  dst_addr;
        logic              seq_access;
        logic              block_done;
        logic              irq_request;
    } rsp_t;

    function automatic logic [3:0] mode_delta(input addr_mode_t mode, input logic word);
        logic [3:0] unit;
        unit = word ? 4'd4 : 4'd2;
        unique case (mode)
            ADDR_DEC:   mode_delta = 4'd0 - unit;
            ADDR_FIXED: mode_delta = 4'd0;
            default:    mode_delta = unit;
        endcase
    endfunction

    function automatic logic [PTR_W-1:0] sext4(input logic [3:0] d);
        sext4 = {{(PTR_W-4){d[3]}}, d};
    endfunction

endpackage

>>> hw/rtl/dma_channel_controller_unit.sv
// One DMA channel sequencer: it produces transfer addresses and control
// status, but does not move data itself.
// Configuration (source, destination, unit count, channel number) is written
// over the APB port; pready is always high. The user must write it only
// while the channel is idle, which the block does not enforce. Requests
// enter on req_type/byte_lane/write_byte/trigger_kind with in_valid and
// in_stall. A request is a control byte write, a trigger event or a transfer
// step. Each request produces exactly one response on the out_* handshake,
// carrying the control value, start and done flags, the address pair and the
// interrupt request. Responses are registered. One request can be accepted
// every cycle while in_stall is low, because all work is one pass of adders
// and compares on the channel registers.
// When the receiver stalls, the response holds and one more response is
// kept in a skid register; in_stall rises only while that skid is full.
// Reset clears the configuration, the control register, the pointers and
// the count to zero and empties both response registers.
module dma_channel_controller_unit
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   req_type,
    input  logic                         byte_lane,
    input  logic [7:0]                   write_byte,
    input  logic [1:0]                   trigger_kind,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [15:0]                  control_value,
    output logic                         start_request,
    output logic                         xfer_valid,
    output logic                         xfer_word32,
    output logic [31:0]                  src_addr,
    output logic [31:0]                  dst_addr,
    output logic                         seq_access,
    output logic                         block_done,
    output logic                         irq_request
);

    logic [dcc_pkg::ADDR_W-1:0]  src_cfg_reg;
    logic [dcc_pkg::ADDR_W-1:0]  dst_cfg_reg;
    logic [15:0]                 count_cfg_reg;
    logic [1:0]                  chan_cfg_reg;

    logic [dcc_pkg::CTRL_W-1:0]  control_reg,    control_next;
    logic [dcc_pkg::COUNT_W-1:0] remain_reg,     remain_next;
    logic                        word_reg,       word_next;
    logic                        moved_reg,      moved_next;
    logic [dcc_pkg::PTR_W-1:0]   src_ptr_reg,    src_ptr_next;
    logic [dcc_pkg::PTR_W-1:0]   dst_ptr_reg,    dst_ptr_next;
    logic [dcc_pkg::PTR_W-1:0]   dst_origin_reg, dst_origin_next;
    logic [3:0]                  src_delta_reg,  src_delta_next;
    logic [3:0]                  dst_delta_reg,  dst_delta_next;

    dcc_pkg::rsp_t               out_data_reg;
    dcc_pkg::rsp_t               skid_data_reg;
    logic                        out_valid_reg;
    logic                        skid_valid_reg;
    dcc_pkg::rsp_t               rsp;

    logic                        cfg_write;
    logic                        in_accept;
    logic                        out_take;
    logic                        out_free;

    logic                        is_ch3;
    logic [15:0]                 count_masked;
    logic [dcc_pkg::COUNT_W-1:0] full_count;
    logic [dcc_pkg::PTR_W-1:0]   src_start;
    logic [dcc_pkg::PTR_W-1:0]   dst_start;
    logic [dcc_pkg::CTRL_W-1:0]  ctrl_written;
    dcc_pkg::timing_t            timing;
    dcc_pkg::addr_mode_t         dst_mode;
    logic                        trig_run;
    logic [dcc_pkg::COUNT_W-1:0] remain_after;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (dcc_pkg::cfg_index_t'(paddr[3:2]))
            dcc_pkg::CFG_SRC:   prdata = {4'd0, src_cfg_reg};
            dcc_pkg::CFG_DST:   prdata = {4'd0, dst_cfg_reg};
            dcc_pkg::CFG_COUNT: prdata = {16'd0, count_cfg_reg};
            dcc_pkg::CFG_CHAN:  prdata = {30'd0, chan_cfg_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cfg_reg   <= '0;
            dst_cfg_reg   <= '0;
            count_cfg_reg <= '0;
            chan_cfg_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (dcc_pkg::cfg_index_t'(paddr[3:2]))
                dcc_pkg::CFG_SRC:   src_cfg_reg   <= pwdata[dcc_pkg::ADDR_W-1:0];
                dcc_pkg::CFG_DST:   dst_cfg_reg   <= pwdata[dcc_pkg::ADDR_W-1:0];
                dcc_pkg::CFG_COUNT: count_cfg_reg <= pwdata[15:0];
                dcc_pkg::CFG_CHAN:  chan_cfg_reg  <= pwdata[1:0];
                default:            chan_cfg_reg  <= chan_cfg_reg;
            endcase
        end
    end

    // Start values derived from the configuration and the channel number.
    assign is_ch3       = (chan_cfg_reg == dcc_pkg::LAST_CHANNEL);
    assign count_masked = is_ch3 ? count_cfg_reg : (count_cfg_reg & dcc_pkg::MASK_14);
    assign full_count   = (count_masked != 16'd0) ? {1'b0, count_masked}
                        : (is_ch3 ? dcc_pkg::MAX_COUNT_LONG : dcc_pkg::MAX_COUNT_SHORT);
    assign src_start    = {4'd0, (chan_cfg_reg == 2'd0) ? (src_cfg_reg & dcc_pkg::MASK_27)
                                                         : src_cfg_reg};
    assign dst_start    = {4'd0, is_ch3 ? dst_cfg_reg : (dst_cfg_reg & dcc_pkg::MASK_27)};

    assign ctrl_written = byte_lane ? {write_byte, control_reg[7:0]}
                                    : {control_reg[15:8], write_byte};
    assign timing       = dcc_pkg::timing_t'(control_reg[dcc_pkg::BIT_TIMING +: 2]);
    assign dst_mode     = dcc_pkg::addr_mode_t'(control_reg[dcc_pkg::BIT_DMODE +: 2]);
    assign remain_after = (remain_reg != '0) ? remain_reg - dcc_pkg::COUNT_W'(1) : remain_reg;

    always_comb
    begin
        trig_run = 1'b0;
        if (control_reg[dcc_pkg::BIT_ENABLE] && timing != dcc_pkg::TIME_NOW)
        begin
            unique case (dcc_pkg::trig_kind_t'(trigger_kind))
                dcc_pkg::TRIG_HBLANK: trig_run = (timing == dcc_pkg::TIME_HBLANK);
                dcc_pkg::TRIG_VBLANK: trig_run = (timing == dcc_pkg::TIME_VBLANK);
                dcc_pkg::TRIG_FIFO_A: trig_run = (timing == dcc_pkg::TIME_SPECIAL)
                                              && (dst_cfg_reg == dcc_pkg::FIFO_A_ADDR);
                dcc_pkg::TRIG_FIFO_B: trig_run = (timing == dcc_pkg::TIME_SPECIAL)
                                              && (dst_cfg_reg == dcc_pkg::FIFO_B_ADDR);
                default:              trig_run = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        control_next    = control_reg;
        remain_next     = remain_reg;
        word_next       = word_reg;
        moved_next      = moved_reg;
        src_ptr_next    = src_ptr_reg;
        dst_ptr_next    = dst_ptr_reg;
        dst_origin_next = dst_origin_reg;
        src_delta_next  = src_delta_reg;
        dst_delta_next  = dst_delta_reg;
        rsp             = '0;

        unique case (dcc_pkg::req_type_t'(req_type))
            dcc_pkg::REQ_CTRL:
            begin
                control_next = ctrl_written;
                if (!control_reg[dcc_pkg::BIT_ENABLE] && ctrl_written[dcc_pkg::BIT_ENABLE])
                begin
                    remain_next     = full_count;
                    moved_next      = 1'b0;
                    word_next       = ctrl_written[dcc_pkg::BIT_WORD];
                    src_ptr_next    = src_start;
                    dst_ptr_next    = dst_start;
                    dst_origin_next = dst_start;
                    dst_delta_next  = dcc_pkg::mode_delta(
                        dcc_pkg::addr_mode_t'(ctrl_written[dcc_pkg::BIT_DMODE +: 2]),
                        ctrl_written[dcc_pkg::BIT_WORD]);
                    src_delta_next  = dcc_pkg::mode_delta(
                        dcc_pkg::addr_mode_t'(ctrl_written[dcc_pkg::BIT_SMODE +: 2]),
                        ctrl_written[dcc_pkg::BIT_WORD]);
                    rsp.start_request = (ctrl_written[dcc_pkg::BIT_TIMING +: 2]
                                         == dcc_pkg::TIME_NOW);
                end
            end
            dcc_pkg::REQ_TRIG:
            begin
                if (trig_run)
                begin
                    moved_next  = 1'b0;
                    remain_next = full_count;
                    if (dst_mode == dcc_pkg::ADDR_RELOAD)
                    begin
                        dst_ptr_next = dst_origin_reg;
                    end
                    if ((chan_cfg_reg == 2'd1 || chan_cfg_reg == 2'd2)
                        && timing == dcc_pkg::TIME_SPECIAL)
                    begin
                        dst_delta_next = 4'd0;
                        remain_next    = dcc_pkg::FIFO_BURST;
                        word_next      = 1'b1;
                    end
                    rsp.start_request = 1'b1;
                end
            end
            dcc_pkg::REQ_STEP:
            begin
                rsp.seq_access  = moved_reg;
                rsp.xfer_word32 = word_reg;
                remain_next     = remain_after;
                if (remain_reg != '0)
                begin
                    rsp.xfer_valid = 1'b1;
                    rsp.src_addr   = src_ptr_reg;
                    rsp.dst_addr   = dst_ptr_reg;
                    moved_next     = 1'b1;
                    src_ptr_next   = src_ptr_reg + dcc_pkg::sext4(src_delta_reg);
                    dst_ptr_next   = dst_ptr_reg + dcc_pkg::sext4(dst_delta_reg);
                end
                if (remain_after == '0)
                begin
                    if (!control_reg[dcc_pkg::BIT_REPEAT])
                    begin
                        control_next[dcc_pkg::BIT_ENABLE] = 1'b0;
                    end
                    rsp.block_done = 1'b1;
                    if (dst_mode == dcc_pkg::ADDR_RELOAD)
                    begin
                        dst_ptr_next = dst_origin_reg;
                    end
                    rsp.irq_request = control_reg[dcc_pkg::BIT_IRQ];
                end
            end
            default:
            begin
                control_next = control_reg;
            end
        endcase
        rsp.control_value = control_next;
    end

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg    <= '0;
            remain_reg     <= '0;
            word_reg       <= 1'b0;
            moved_reg      <= 1'b0;
            src_ptr_reg    <= '0;
            dst_ptr_reg    <= '0;
            dst_origin_reg <= '0;
            src_delta_reg  <= '0;
            dst_delta_reg  <= '0;
        end
        else if (in_accept)
        begin
            control_reg    <= control_next;
            remain_reg     <= remain_next;
            word_reg       <= word_next;
            moved_reg      <= moved_next;
            src_ptr_reg    <= src_ptr_next;
            dst_ptr_reg    <= dst_ptr_next;
            dst_origin_reg <= dst_origin_next;
            src_delta_reg  <= src_delta_next;
            dst_delta_reg  <= dst_delta_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (out_free)
            begin
                out_data_reg <= rsp;
            end
            else
            begin
                skid_data_reg <= rsp;
            end
        end
        else if (out_free && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign in_stall      = skid_valid_reg;
    assign out_valid     = out_valid_reg;
    assign control_value = out_data_reg.control_value;
    assign start_request = out_data_reg.start_request;
    assign xfer_valid    = out_data_reg.xfer_valid;
    assign xfer_word32   = out_data_reg.xfer_word32;
    assign src_addr      = out_data_reg.src_addr;
    assign dst_addr      = out_data_reg.dst_addr;
    assign seq_access    = out_data_reg.seq_access;
    assign block_done    = out_data_reg.block_done;
    assign irq_request   = out_data_reg.irq_request;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a response while the output register is empty.");

    a_accept_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !out_valid_reg) |=> out_valid_reg)
        else $error("Accepted request did not produce a response.");

    a_idle_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.xfer_valid) |->
            (out_data_reg.src_addr == '0 && out_data_reg.dst_addr == '0))
        else $error("Addresses reported without a transfer.");

    a_done_disables: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.block_done
            && !out_data_reg.control_value[dcc_pkg::BIT_REPEAT])
            |-> !out_data_reg.control_value[dcc_pkg::BIT_ENABLE])
        else $error("Finished block without repeat left the channel enabled.");

endmodule
